// File: src/gtpu_echo_responder_macros.svh
// Assertion macros for the echo responder RTL.
`ifndef GTPU_ECHO_RESPONDER_MACROS_SVH
`define GTPU_ECHO_RESPONDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gte_pkg.sv
// Types, constants and the response byte table for the echo responder.
package gte_pkg;

    localparam logic [7:0] FLAG_VERSION1 = 8'h20;
    localparam logic [7:0] FLAG_PT       = 8'h10;
    localparam logic [2:0] VERSION_1     = 3'd1;
    localparam logic [7:0] TYPE_ECHO_REQ = 8'd1;
    localparam logic [7:0] TYPE_ECHO_RSP = 8'd2;
    localparam logic [7:0] IE_RECOVERY   = 8'd14;
    localparam logic [7:0] LEN_NO_OPT    = 8'd2;
    localparam logic [7:0] LEN_OPT       = 8'd6;

    // Header offsets
    localparam logic [3:0] POS_FLAGS   = 4'd0;
    localparam logic [3:0] POS_TYPE    = 4'd1;
    localparam logic [3:0] POS_SEQ_HI  = 4'd8;
    localparam logic [3:0] POS_SEQ_LO  = 4'd9;
    localparam logic [3:0] POS_NPDU    = 4'd10;
    localparam logic [3:0] POS_MAX     = 4'd15;
    localparam logic [3:0] POS_MIN_HDR = 4'd7;   // last offset of the mandatory header
    localparam logic [3:0] POS_MIN_OPT = 4'd11;  // last offset with optional fields

    // Response byte indexes
    localparam logic [3:0] IDX_FLAGS    = 4'd0;
    localparam logic [3:0] IDX_TYPE     = 4'd1;
    localparam logic [3:0] IDX_LEN_LO   = 4'd3;
    localparam logic [3:0] IDX_SEQ_HI   = 4'd8;
    localparam logic [3:0] IDX_SEQ_LO   = 4'd9;
    localparam logic [3:0] IDX_NPDU     = 4'd10;
    localparam logic [3:0] IDX_IE       = 4'd12;
    localparam logic [3:0] IDX_OPT_SKIP = 4'd4;
    localparam logic [3:0] IDX_LAST_NO  = 4'd9;
    localparam logic [3:0] IDX_LAST_OPT = 4'd13;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // One pending response: S and PN bits plus the copied fields
    typedef struct packed {
        logic [1:0]  opts;
        logic [15:0] seq;
        logic [7:0]  npdu;
    } t_job;

    // Index of the final response byte
    function automatic logic [3:0] resp_last_idx(input t_job job);
        return (job.opts != 2'b00) ? IDX_LAST_OPT : IDX_LAST_NO;
    endfunction

    // Response byte at a given index; short responses skip the optional block
    function automatic logic [7:0] resp_byte(input t_job job, input logic [3:0] idx);
        logic [3:0] k;
        logic [7:0] b;
        k = ((job.opts == 2'b00) && (idx >= IDX_SEQ_HI)) ? idx + IDX_OPT_SKIP : idx;
        case (k)
            IDX_FLAGS:  b = FLAG_VERSION1 | FLAG_PT | {6'd0, job.opts};
            IDX_TYPE:   b = TYPE_ECHO_RSP;
            IDX_LEN_LO: b = (job.opts != 2'b00) ? LEN_OPT : LEN_NO_OPT;
            IDX_SEQ_HI: b = job.opts[1] ? job.seq[15:8] : 8'd0;
            IDX_SEQ_LO: b = job.opts[1] ? job.seq[7:0] : 8'd0;
            IDX_NPDU:   b = job.opts[0] ? job.npdu : 8'd0;
            IDX_IE:     b = IE_RECOVERY;
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// File: src/gte_front.sv
// Front end: tracks byte offset, captures header fields, queues echo requests.
module gte_front import gte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_beat i_data,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_push_job
);

    logic [3:0]  r_pos;
    logic [7:0]  r_flags;
    logic [7:0]  r_type;
    logic [15:0] r_seq;
    logic [7:0]  r_npdu;
    logic        w_accept;
    logic [1:0]  w_opts;
    logic        w_request_ok;

    // Only a final byte needs queue space
    assign o_ready  = !i_q_full || !i_data.in_last;
    assign w_accept = i_valid && o_ready;
    assign w_opts   = r_flags[1:0];

    // Echo request check; the fields it reads were captured on earlier beats
    assign w_request_ok = (r_flags[7:5] == VERSION_1) && (r_type == TYPE_ECHO_REQ)
                        && (r_pos >= POS_MIN_HDR)
                        && ((w_opts == 2'b00) || (r_pos >= POS_MIN_OPT));

    assign o_push          = w_accept && i_data.in_last && w_request_ok;
    assign o_push_job.opts = w_opts;
    assign o_push_job.seq  = r_seq;
    assign o_push_job.npdu = r_npdu;

    // Offset counter and field capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_flags <= '0;
            r_type  <= '0;
            r_seq   <= '0;
            r_npdu  <= '0;
        end else if (w_accept) begin
            case (r_pos)
                POS_FLAGS:  r_flags     <= i_data.in_byte;
                POS_TYPE:   r_type      <= i_data.in_byte;
                POS_SEQ_HI: r_seq[15:8] <= i_data.in_byte;
                POS_SEQ_LO: r_seq[7:0]  <= i_data.in_byte;
                POS_NPDU:   r_npdu      <= i_data.in_byte;
                default: ;
            endcase
            if (i_data.in_last) begin
                r_pos <= '0;
            end else if (r_pos != POS_MAX) begin
                r_pos <= r_pos + 4'd1;
            end
        end
    end

endmodule

// File: src/gte_queue.sv
// Small job queue between the front end and the response generator.
`include "gtpu_echo_responder_macros.svh"
module gte_queue import gte_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_job,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_FULL);
    assign o_empty   = (r_count == '0);
    assign o_pop_job = r_slot[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `GTE_ASSERT_IMPL(a_no_overflow, i_push, !o_full, "queue push while full")
    `GTE_ASSERT_IMPL(a_no_underflow, i_pop, !o_empty, "queue pop while empty")
    `GTE_ASSERT_NEXT(a_push_lands, i_push && !i_pop, !o_empty, "pushed job not visible")
    `GTE_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_FULL, "queue count out of range")

endmodule

// File: src/gte_back.sv
// Back end: walks a queued job and emits the echo response through an output register.
module gte_back import gte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_q_job,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic       r_busy;
    logic [3:0] r_idx;
    t_job       r_job;
    logic       r_out_valid;
    t_out_beat  r_out;
    logic       w_load;
    logic       w_final;

    assign o_pop   = !r_busy && !i_q_empty;
    assign w_load  = !r_out_valid || i_ready;
    assign w_final = (r_idx == resp_last_idx(r_job));
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Job pickup, byte sequencing and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_job  <= i_q_job;
                r_idx  <= '0;
            end
            if (w_load) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_out.out_byte <= resp_byte(r_job, r_idx);
                    r_out.out_last <= w_final;
                    r_idx          <= r_idx + 4'd1;
                    if (w_final) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

endmodule

// File: src/gtpu_echo_responder.sv
// Top level of the GTP-U echo responder: front end, job queue, response generator.
//
//   Channel   Dir  Handshake           Payload
//   request   in   i_valid / o_ready   i_data (t_in_beat: in_byte, in_last)
//   response  out  o_valid / i_ready   o_data (t_out_beat: out_byte, out_last)
//
// Request bytes are taken one per cycle; a final beat stalls only while the job queue is full.
// A valid echo request enters the queue on its final beat; with the generator idle it is
// picked up from the queue, then the output register sends one beat per cycle while i_ready
// is high (10 or 14 beats). The job pickup leaves an idle gap between consecutive responses.
// Synchronous active-low reset clears the offset, captured fields, queue and output.
module gtpu_echo_responder import gte_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_pop;
    t_job w_pop_job;
    logic w_empty;

    gte_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_push_job (w_push_job)
    );

    gte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_pop_job  (w_pop_job),
        .o_empty    (w_empty)
    );

    gte_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_empty),
        .i_q_job   (w_pop_job),
        .o_pop     (w_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

// File: verif/gte_echo_checker.sv
// Checker for the echo responder: tracks request beats, predicts response beats, compares.
module gte_echo_checker import gte_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_in_beat  i_req_data,
    input  logic      i_rsp_valid,
    input  logic      i_rsp_ready,
    input  t_out_beat i_rsp_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_beats_checked
);

    localparam int         MAX_REPORTS = 10;
    localparam logic [1:0] OPTS_NONE   = 2'b00;
    localparam int         OPT_S       = 1;
    localparam int         OPT_PN      = 0;

    // Header fields captured from the request stream
    logic [3:0]  rx_pos   = '0;
    logic [7:0]  rx_flags = '0;
    logic [7:0]  rx_type  = '0;
    logic [15:0] rx_seq   = '0;
    logic [7:0]  rx_npdu  = '0;

    t_out_beat awaited_rsp_beats[$];
    int        fail_count    = 0;
    int        beats_checked = 0;
    int        pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_beats_checked = beats_checked;

    task automatic flag_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    // Capture one request byte; on the final beat queue the echo response, if any
    task automatic take_request_byte(input t_in_beat beat);
        logic [3:0] pos;
        logic [1:0] opts;
        logic [7:0] rsp[$];
        t_out_beat  rsp_beat;
        pos = rx_pos;
        case (pos)
            POS_FLAGS:  rx_flags = beat.in_byte;
            POS_TYPE:   rx_type = beat.in_byte;
            POS_SEQ_HI: rx_seq[15:8] = beat.in_byte;
            POS_SEQ_LO: rx_seq[7:0] = beat.in_byte;
            POS_NPDU:   rx_npdu = beat.in_byte;
            default: ;
        endcase
        if (beat.in_last) begin
            rx_pos = '0;
            opts = rx_flags[1:0];
            // version 1 echo request, long enough for its header
            if (rx_flags[7:5] == VERSION_1 && rx_type == TYPE_ECHO_REQ &&
                pos >= POS_MIN_HDR && (opts == OPTS_NONE || pos >= POS_MIN_OPT)) begin
                rsp.push_back(FLAG_VERSION1 | FLAG_PT | {6'd0, opts});
                rsp.push_back(TYPE_ECHO_RSP);
                rsp.push_back(8'h00);
                rsp.push_back((opts != OPTS_NONE) ? LEN_OPT : LEN_NO_OPT);
                repeat (4) rsp.push_back(8'h00);  // TEID
                if (opts != OPTS_NONE) begin
                    rsp.push_back(opts[OPT_S] ? rx_seq[15:8] : 8'h00);
                    rsp.push_back(opts[OPT_S] ? rx_seq[7:0] : 8'h00);
                    rsp.push_back(opts[OPT_PN] ? rx_npdu : 8'h00);
                    rsp.push_back(8'h00);  // no next extension
                end
                rsp.push_back(IE_RECOVERY);
                rsp.push_back(8'h00);
                foreach (rsp[i]) begin
                    rsp_beat.out_byte = rsp[i];
                    rsp_beat.out_last = (i == rsp.size() - 1);
                    awaited_rsp_beats.push_back(rsp_beat);
                end
            end
        end else if (pos != POS_MAX) begin
            rx_pos = pos + 4'd1;
        end
    endtask

    // Watch both channels at each edge
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            rx_pos = '0;
            rx_flags = '0;
            rx_type = '0;
            rx_seq = '0;
            rx_npdu = '0;
            awaited_rsp_beats.delete();
        end else begin
            if (i_req_valid && i_req_ready) take_request_byte(i_req_data);
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp_beats.size() == 0) begin
                    flag_failure($sformatf("unexpected response beat: byte %h last %b",
                                           i_rsp_data.out_byte, i_rsp_data.out_last));
                end else begin
                    want = awaited_rsp_beats.pop_front();
                    beats_checked++;
                    if (i_rsp_data.out_byte !== want.out_byte ||
                        i_rsp_data.out_last !== want.out_last) begin
                        flag_failure($sformatf(
                            "response beat mismatch: expected byte %h last %b, got byte %h last %b",
                            want.out_byte, want.out_last,
                            i_rsp_data.out_byte, i_rsp_data.out_last));
                    end
                end
            end
        end
        pending_count <= awaited_rsp_beats.size();
    end

endmodule

// File: verif/testbench.sv
// Testbench top for the echo responder: request packet stimulus, back-pressure and verdict.
module testbench;
    import gte_pkg::*;

    localparam int         CLK_PERIOD     = 12;
    localparam int         RESET_CYCLES   = 10;
    localparam int         TIMEOUT_CYCLES = 200000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         HOLD_PACKETS   = 4;
    localparam int         PHASE_BYTES    = 32;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         HDR_BYTES      = 8;
    localparam int         OPT_BYTES      = 4;
    localparam logic [7:0] FLAG_S_PN      = 8'h03;

    typedef enum int {PKT_ECHO, PKT_BAD_VERSION, PKT_BAD_TYPE, PKT_SHORT, PKT_NOISE} t_pkt_kind;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_beat  i_data  = '0;
    logic      i_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_beat o_data;

    int fail_count;
    int rsp_pending;
    int rsp_checked;

    // Stimulus knobs, shared with the response side
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_done = 1'b0;

    logic [7:0] pkt[$];
    int         bytes_sent   = 0;
    int         packets_sent = 0;
    int         echo_built   = 0;

    gtpu_echo_responder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    gte_echo_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_data      (i_data),
        .i_rsp_valid     (o_valid),
        .i_rsp_ready     (i_ready),
        .i_rsp_data      (o_data),
        .o_fail_count    (fail_count),
        .o_pending       (rsp_pending),
        .o_beats_checked (rsp_checked)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input logic [7:0] data_byte, input logic is_last);
        t_in_beat beat;
        beat.in_byte = data_byte;
        beat.in_last = is_last;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= beat;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) send_beat(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // Random packet of the given kind; header fields are valid unless the kind breaks them
    task automatic build_packet(input t_pkt_kind kind);
        logic [7:0] flags;
        logic [7:0] msg;
        logic [2:0] ver;
        int         min_len;
        int         len;
        int         r;
        flags = 8'($urandom);
        flags[7:5] = VERSION_1;
        msg = TYPE_ECHO_REQ;
        min_len = (flags[1:0] != 2'b00) ? HDR_BYTES + OPT_BYTES : HDR_BYTES;
        r = $urandom_range(9);
        // mostly exact or slightly long; some run past the saturation point
        len = min_len + ((r < 4) ? 0 : (r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 9));
        case (kind)
            PKT_BAD_VERSION: begin
                do ver = 3'($urandom_range(7)); while (ver == VERSION_1);
                flags[7:5] = ver;
            end
            PKT_BAD_TYPE: do msg = 8'($urandom); while (msg == TYPE_ECHO_REQ);
            PKT_SHORT:    len = $urandom_range(1, min_len - 1);
            PKT_NOISE:    len = $urandom_range(1, 16);
            default: ;
        endcase
        pkt.delete();
        repeat (len) pkt.push_back(8'($urandom));
        if (kind != PKT_NOISE) begin
            pkt[0] = flags;
            if (len > 1) pkt[1] = msg;
        end
        if (kind == PKT_ECHO) echo_built++;
    endtask

    // Response side: random stalls, plus one long hold-off on request
    initial begin
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Main stimulus and verdict
    initial begin
        int r;
        int phase_end;
        t_pkt_kind kind;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // minimal echo request, no optional fields, filler all ones
        pkt = '{FLAG_VERSION1 | FLAG_PT, TYPE_ECHO_REQ,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet();
        // S and PN set, sequence and N-PDU at their maximum
        pkt = '{FLAG_VERSION1 | FLAG_PT | FLAG_S_PN, TYPE_ECHO_REQ,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_packet();
        // version bits all set: dropped
        pkt = '{8'hE0, TYPE_ECHO_REQ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        // single-byte packet: too short
        pkt = '{FLAG_VERSION1 | FLAG_S_PN};
        send_packet();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 61; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            // fill the block while the response side holds off
            if (phase == 0) begin
                hold_req <= 1'b1;
                repeat (HOLD_PACKETS) begin
                    build_packet(PKT_ECHO);
                    send_packet();
                end
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                r = $urandom_range(99);
                kind = (r < 60) ? PKT_ECHO : (r < 70) ? PKT_BAD_VERSION :
                       (r < 80) ? PKT_BAD_TYPE : (r < 90) ? PKT_SHORT : PKT_NOISE;
                build_packet(kind);
                send_packet();
            end
        end
        i_valid <= 1'b0;

        do @(posedge i_clk); while (rsp_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d request beats in %0d packets (%0d random echo requests)",
                 bytes_sent, packets_sent, echo_built);
        $display("Checked %0d response beats across four idle/stall mixes and one long hold-off",
                 rsp_checked);
        if (fail_count == 0 && rsp_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: gtpu_echo_responder.f
+incdir+src
src/gte_pkg.sv
src/gte_front.sv
src/gte_queue.sv
src/gte_back.sv
src/gtpu_echo_responder.sv
verif/gte_echo_checker.sv
verif/testbench.sv
